>>> design/gmps_pkg.sv
`default_nettype none

package gmps_pkg;

	// grid storage
	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	localparam int CELLS    = MAX_ROWS * MAX_COLS;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int CELL_W   = $clog2(CELLS);
	localparam int DEPTH_W  = $clog2(CELLS + 1);
	localparam int NROW_W   = $clog2(MAX_ROWS + 1);
	localparam int NCOL_W   = $clog2(MAX_COLS + 1);

	// item and register field widths
	localparam int POS_W      = 4;
	localparam int SIZE_W     = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	// goal index as the register fields give it, may lie outside the grid in use
	localparam int GOAL_RAW_W = $clog2((2 ** POS_W - 1) * MAX_COLS + 2 ** POS_W);
	localparam int GOAL_W     = (GOAL_RAW_W > CELL_W) ? GOAL_RAW_W : CELL_W;

	// visited marks carry the search epoch; zero never marks a cell visited
	localparam int EPOCH_W = 4;
	localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(16);
	localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(16);

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_END_ROW   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_COL   = 3'd5;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	typedef struct packed {
		logic [NROW_W-1:0] rows;
		logic [NCOL_W-1:0] cols;
		logic [POS_W-1:0]  start_row;
		logic [POS_W-1:0]  start_col;
		logic [POS_W-1:0]  end_row;
		logic [POS_W-1:0]  end_col;
	} cfg_t;

	typedef struct packed {
		logic               open;
		logic [EPOCH_W-1:0] epoch;
	} cell_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [1:0]       dir;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [CELL_W-1:0] waddr;
		cell_t             wdata;
		logic [CELL_W-1:0] raddr;
	} cell_req_t;

	typedef struct packed {
		logic              we;
		logic [CELL_W-1:0] waddr;
		entry_t            wdata;
		logic [CELL_W-1:0] raddr;
	} stk_req_t;

	function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
	                                                input logic [COL_W-1:0] col);
		return CELL_W'(int'(row) * MAX_COLS + int'(col));
	endfunction

endpackage

`default_nettype wire

>>> design/gmps_if.sv
`default_nettype none

interface gmps_req_if;
	import gmps_pkg::*;

	logic             valid;
	logic             ready;
	logic             kind;
	logic [POS_W-1:0] cell_row;
	logic [POS_W-1:0] cell_col;
	logic             cell_open;

	modport source(output valid, kind, cell_row, cell_col, cell_open, input ready);
	modport sink(input valid, kind, cell_row, cell_col, cell_open, output ready);
endinterface

interface gmps_rsp_if;
	logic valid;
	logic ready;
	logic path_found;

	modport source(output valid, path_found, input ready);
	modport sink(input valid, path_found, output ready);
endinterface

`default_nettype wire

>>> design/gmps_ram.sv
`default_nettype none

module gmps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> design/gmps_cfg.sv
`default_nettype none

module gmps_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             we,
	input  wire logic [gmps_pkg::CFG_IDX_W-1:0]   idx,
	input  wire logic [gmps_pkg::CFG_DATA_W-1:0]  data,
	output gmps_pkg::cfg_t                        cfg
);
	import gmps_pkg::*;

	logic [SIZE_W-1:0] num_rows_q;
	logic [SIZE_W-1:0] num_cols_q;
	logic [POS_W-1:0]  start_row_q;
	logic [POS_W-1:0]  start_col_q;
	logic [POS_W-1:0]  end_row_q;
	logic [POS_W-1:0]  end_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q  <= ROWS_RESET;
			num_cols_q  <= COLS_RESET;
			start_row_q <= '0;
			start_col_q <= '0;
			end_row_q   <= '0;
			end_col_q   <= '0;
		end else if (we) begin
			unique case (idx)
				REG_NUM_ROWS:  num_rows_q  <= data[SIZE_W-1:0];
				REG_NUM_COLS:  num_cols_q  <= data[SIZE_W-1:0];
				REG_START_ROW: start_row_q <= data[POS_W-1:0];
				REG_START_COL: start_col_q <= data[POS_W-1:0];
				REG_END_ROW:   end_row_q   <= data[POS_W-1:0];
				REG_END_COL:   end_col_q   <= data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate the grid size at the storage bounds
	always_comb begin
		cfg.rows      = (int'(num_rows_q) > MAX_ROWS) ? NROW_W'(MAX_ROWS) : NROW_W'(num_rows_q);
		cfg.cols      = (int'(num_cols_q) > MAX_COLS) ? NCOL_W'(MAX_COLS) : NCOL_W'(num_cols_q);
		cfg.start_row = start_row_q;
		cfg.start_col = start_col_q;
		cfg.end_row   = end_row_q;
		cfg.end_col   = end_col_q;
	end

endmodule

`default_nettype wire

>>> design/gmps_walk.sv
`default_nettype none

module gmps_walk (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gmps_pkg::cfg_t    cfg,
	gmps_req_if.sink               req,
	gmps_rsp_if.source             rsp,
	output gmps_pkg::cell_req_t    cell_req,
	input  wire gmps_pkg::cell_t   cell_rdata,
	output gmps_pkg::stk_req_t     stk_req,
	input  wire gmps_pkg::entry_t  stk_rdata
);
	import gmps_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_CLEAR    = 3'd1;
	localparam logic [2:0] ST_START_RD = 3'd2;
	localparam logic [2:0] ST_START_WR = 3'd3;
	localparam logic [2:0] ST_CHECK    = 3'd4;
	localparam logic [2:0] ST_EVAL     = 3'd5;
	localparam logic [2:0] ST_LOAD     = 3'd6;
	localparam logic [2:0] ST_FINISH   = 3'd7;

	logic [2:0]         state_q, state_d;
	logic [EPOCH_W-1:0] epoch_q, epoch_d;
	logic [CELL_W:0]    clr_q, clr_d;
	entry_t             top_q, top_d;
	logic [DEPTH_W-1:0] depth_q, depth_d;
	logic [ROW_W-1:0]   nbr_row_q, nbr_row_d;
	logic [COL_W-1:0]   nbr_col_q, nbr_col_d;
	logic               found_q, found_d;
	logic               rsp_valid_q, rsp_valid_d;
	logic               rsp_found_q, rsp_found_d;

	logic               step_ok;
	logic [ROW_W-1:0]   step_row;
	logic [COL_W-1:0]   step_col;
	logic               do_pop;
	logic               entered;
	logic               last_dir;
	logic               start_ok;
	logic [ROW_W-1:0]   start_row;
	logic [COL_W-1:0]   start_col;
	logic [GOAL_W-1:0]  goal;
	logic [GOAL_W-1:0]  nbr_idx;

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.path_found = rsp_found_q;

	assign start_ok  = (int'(cfg.start_row) < int'(cfg.rows)) &&
	                   (int'(cfg.start_col) < int'(cfg.cols));
	assign start_row = ROW_W'(cfg.start_row);
	assign start_col = COL_W'(cfg.start_col);
	assign goal      = GOAL_W'(int'(cfg.end_row) * MAX_COLS + int'(cfg.end_col));
	assign nbr_idx   = GOAL_W'(cell_addr(nbr_row_q, nbr_col_q));
	assign entered   = cell_rdata.open && (cell_rdata.epoch != epoch_q);
	assign last_dir  = (top_q.dir == DIR_W);

	// neighbor of the top cell in its current direction
	always_comb begin
		step_ok  = 1'b0;
		step_row = top_q.row;
		step_col = top_q.col;
		case (top_q.dir)
			DIR_N: begin
				step_ok  = (top_q.row != '0);
				step_row = top_q.row - ROW_W'(1);
			end
			DIR_E: begin
				step_ok  = (int'(top_q.col) + 1 < int'(cfg.cols));
				step_col = top_q.col + COL_W'(1);
			end
			DIR_S: begin
				step_ok  = (int'(top_q.row) + 1 < int'(cfg.rows));
				step_row = top_q.row + ROW_W'(1);
			end
			default: begin
				step_ok  = (top_q.col != '0);
				step_col = top_q.col - COL_W'(1);
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		epoch_d     = epoch_q;
		clr_d       = clr_q;
		top_d       = top_q;
		depth_d     = depth_q;
		nbr_row_d   = nbr_row_q;
		nbr_col_d   = nbr_col_q;
		found_d     = found_q;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		rsp_found_d = rsp_found_q;
		cell_req    = '0;
		stk_req     = '0;
		do_pop      = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (req.kind == KIND_WRITE) begin
						if (int'(req.cell_row) < MAX_ROWS && int'(req.cell_col) < MAX_COLS) begin
							cell_req.we    = 1'b1;
							cell_req.waddr = cell_addr(ROW_W'(req.cell_row), COL_W'(req.cell_col));
							cell_req.wdata = '{open: req.cell_open, epoch: EPOCH_NONE};
						end
					end else if (cfg.start_row == cfg.end_row && cfg.start_col == cfg.end_col) begin
						found_d = 1'b1;
						state_d = ST_FINISH;
					end else if (epoch_q == EPOCH_NONE || epoch_q == EPOCH_LAST) begin
						epoch_d = EPOCH_FIRST;
						clr_d   = '0;
						state_d = ST_CLEAR;
					end else begin
						epoch_d = epoch_q + EPOCH_W'(1);
						state_d = ST_START_RD;
					end
				end
			end
			ST_CLEAR: begin
				// read one entry ahead, write back its open bit with the mark dropped
				cell_req.raddr = clr_q[CELL_W-1:0];
				if (clr_q != '0) begin
					cell_req.we    = 1'b1;
					cell_req.waddr = CELL_W'(clr_q - (CELL_W+1)'(1));
					cell_req.wdata = '{open: cell_rdata.open, epoch: EPOCH_NONE};
				end
				clr_d = clr_q + (CELL_W+1)'(1);
				if (int'(clr_q) == CELLS) begin
					state_d = ST_START_RD;
				end
			end
			ST_START_RD: begin
				cell_req.raddr = cell_addr(start_row, start_col);
				found_d        = 1'b0;
				state_d        = start_ok ? ST_START_WR : ST_FINISH;
			end
			ST_START_WR: begin
				cell_req.we    = 1'b1;
				cell_req.waddr = cell_addr(start_row, start_col);
				cell_req.wdata = '{open: cell_rdata.open, epoch: epoch_q};
				top_d          = '{row: start_row, col: start_col, dir: DIR_N};
				depth_d        = DEPTH_W'(1);
				state_d        = ST_CHECK;
			end
			ST_CHECK: begin
				nbr_row_d = step_row;
				nbr_col_d = step_col;
				if (step_ok) begin
					cell_req.raddr = cell_addr(step_row, step_col);
					state_d        = ST_EVAL;
				end else if (last_dir) begin
					do_pop = 1'b1;
				end else begin
					top_d.dir = top_q.dir + 2'd1;
				end
			end
			ST_EVAL: begin
				if (entered) begin
					cell_req.we    = 1'b1;
					cell_req.waddr = cell_addr(nbr_row_q, nbr_col_q);
					cell_req.wdata = '{open: 1'b1, epoch: epoch_q};
					if (nbr_idx == goal) begin
						found_d = 1'b1;
						state_d = ST_FINISH;
					end else if (last_dir) begin
						// top is done: replace it by the new cell
						top_d   = '{row: nbr_row_q, col: nbr_col_q, dir: DIR_N};
						state_d = ST_CHECK;
					end else begin
						top_d.dir = top_q.dir + 2'd1;
						if (int'(depth_q) < CELLS) begin
							stk_req.we    = 1'b1;
							stk_req.waddr = CELL_W'(depth_q - DEPTH_W'(1));
							stk_req.wdata = '{row: top_q.row, col: top_q.col,
							                  dir: top_q.dir + 2'd1};
							top_d         = '{row: nbr_row_q, col: nbr_col_q, dir: DIR_N};
							depth_d       = depth_q + DEPTH_W'(1);
						end
						state_d = ST_CHECK;
					end
				end else if (last_dir) begin
					do_pop = 1'b1;
				end else begin
					top_d.dir = top_q.dir + 2'd1;
					state_d   = ST_CHECK;
				end
			end
			ST_LOAD: begin
				top_d   = stk_rdata;
				state_d = ST_CHECK;
			end
			ST_FINISH: begin
				// hold the result until the output register is free
				if (!rsp_valid_q || rsp.ready) begin
					rsp_valid_d = 1'b1;
					rsp_found_d = found_q;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (do_pop) begin
			depth_d = depth_q - DEPTH_W'(1);
			if (depth_q == DEPTH_W'(1)) begin
				found_d = 1'b0;
				state_d = ST_FINISH;
			end else begin
				stk_req.raddr = CELL_W'(depth_q - DEPTH_W'(2));
				state_d       = ST_LOAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			epoch_q     <= EPOCH_NONE;
			clr_q       <= '0;
			depth_q     <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			epoch_q     <= epoch_d;
			clr_q       <= clr_d;
			depth_q     <= depth_d;
			found_q     <= found_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q       <= top_d;
		nbr_row_q   <= nbr_row_d;
		nbr_col_q   <= nbr_col_d;
		rsp_found_q <= rsp_found_d;
	end

endmodule

`default_nettype wire

>>> design/grid_maze_path_search.sv
// Write item: the cell is written and the next item is taken in the following cycle.
// Search item: each neighbor probe reads the cell memory and each backtrack
// reads the stack memory, plus a visited-mark sweep over the cell memory on
// the first search after reset and every 15th.
// The result sits in an output register; a new item is taken while it waits.
// Reset restores register defaults and clears control state; grid is undefined.
`default_nettype none

module grid_maze_path_search (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	gmps_req_if.sink                              req,
	gmps_rsp_if.source                            rsp,
	input  wire logic                             cfg_we,
	input  wire logic [gmps_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [gmps_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import gmps_pkg::*;

	cfg_t                  cfg;
	cell_req_t             cell_req;
	stk_req_t              stk_req;
	logic [$bits(cell_t)-1:0]  cell_raw;
	logic [$bits(entry_t)-1:0] stk_raw;

	gmps_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	gmps_ram #(
		.WIDTH ($bits(cell_t)),
		.DEPTH (CELLS)
	) u_cell_ram (
		.clk   (clk),
		.we    (cell_req.we),
		.waddr (cell_req.waddr),
		.wdata (cell_req.wdata),
		.raddr (cell_req.raddr),
		.rdata (cell_raw)
	);

	gmps_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (CELLS)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_req.we),
		.waddr (stk_req.waddr),
		.wdata (stk_req.wdata),
		.raddr (stk_req.raddr),
		.rdata (stk_raw)
	);

	gmps_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req        (req),
		.rsp        (rsp),
		.cell_req   (cell_req),
		.cell_rdata (cell_t'(cell_raw)),
		.stk_req    (stk_req),
		.stk_rdata  (entry_t'(stk_raw))
	);

endmodule

`default_nettype wire

>>> design/gmps_chk.sv
`default_nettype none

module gmps_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic req_kind,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic rsp_path_found
);
	import gmps_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_path_found))
		else $error("result dropped or changed while stalled");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_kind == KIND_SEARCH |=> !req_ready)
		else $error("item taken while a search is running");

	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_kind == KIND_WRITE |=> req_ready)
		else $error("cell write stalled the input");

	a_rsp_from_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared without a finished search");

endmodule

bind grid_maze_path_search gmps_chk u_gmps_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_kind       (req.kind),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_path_found (rsp.path_found)
);

`default_nettype wire

>>> test/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gmps_pkg::*;

	localparam int QUIET_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 20;
	localparam int TAIL_CYCLES   = 50;
	localparam int LONG_HOLD     = 300;
	localparam int PHASES        = 26;
	localparam int PHASE_ITEMS   = 20;

	typedef enum int {RSP_ALWAYS, RSP_COIN, RSP_PATTERN, RSP_MOSTLY} rsp_style_t;

	// Tracks the grid and registers, predicts path_found for each search item.
	class path_scoreboard;
		bit open_map[CELLS];
		int rows_cfg, cols_cfg, start_r, start_c, end_r, end_c;
		bit found_q[$];
		int errors;

		function new();
			rows_cfg = int'(ROWS_RESET);
			cols_cfg = int'(COLS_RESET);
			start_r = 0;
			start_c = 0;
			end_r = 0;
			end_c = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_NUM_ROWS: rows_cfg = int'(data);
			REG_NUM_COLS: cols_cfg = int'(data);
			REG_START_ROW: start_r = int'(data[POS_W-1:0]);
			REG_START_COL: start_c = int'(data[POS_W-1:0]);
			REG_END_ROW: end_r = int'(data[POS_W-1:0]);
			REG_END_COL: end_c = int'(data[POS_W-1:0]);
			default: ;
			endcase
		endfunction

		function int pending();
			return found_q.size();
		endfunction

		// Depth-first walk, neighbors tried north, east, south, west.
		function bit reach_goal();
			bit seen[CELLS];
			int cell_stk[$];
			logic [1:0] dir_stk[$];
			int rows, cols, goal, top, r, c, nr, nc, n;
			logic [1:0] dir;
			bit ok;
			if (start_r == end_r && start_c == end_c)
				return 1'b1;
			rows = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
			cols = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
			if (start_r >= rows || start_c >= cols)
				return 1'b0;
			goal = end_r * MAX_COLS + end_c;
			// start counts as visited even when it is a wall
			seen[start_r * MAX_COLS + start_c] = 1'b1;
			cell_stk.push_back(start_r * MAX_COLS + start_c);
			dir_stk.push_back(DIR_N);
			while (cell_stk.size() > 0) begin
				top = cell_stk.size() - 1;
				r = cell_stk[top] / MAX_COLS;
				c = cell_stk[top] % MAX_COLS;
				dir = dir_stk[top];
				if (dir == DIR_W) begin
					void'(cell_stk.pop_back());
					void'(dir_stk.pop_back());
				end else begin
					dir_stk[top] = dir + 2'd1;
				end
				ok = 1'b0;
				nr = r;
				nc = c;
				case (dir)
				DIR_N: if (r > 0) begin
					nr = r - 1;
					ok = 1'b1;
				end
				DIR_E: if (c + 1 < cols) begin
					nc = c + 1;
					ok = 1'b1;
				end
				DIR_S: if (r + 1 < rows) begin
					nr = r + 1;
					ok = 1'b1;
				end
				default: if (c > 0) begin
					nc = c - 1;
					ok = 1'b1;
				end
				endcase
				if (ok) begin
					n = nr * MAX_COLS + nc;
					if (open_map[n] && !seen[n]) begin
						seen[n] = 1'b1;
						if (n == goal)
							return 1'b1;
						cell_stk.push_back(n);
						dir_stk.push_back(DIR_N);
					end
				end
			end
			return 1'b0;
		endfunction

		function void note_item(logic kind, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
		                        logic open_bit);
			if (kind == KIND_WRITE)
				open_map[int'(row) * MAX_COLS + int'(col)] = open_bit;
			else
				found_q.push_back(reach_goal());
		endfunction

		function void check_result(logic found);
			bit exp_found;
			if (found_q.size() == 0) begin
				$error("path_found: expected nothing, got %0b", found);
				errors++;
			end else begin
				exp_found = found_q.pop_front();
				if (found !== exp_found) begin
					$error("path_found: expected %0b, got %0b", exp_found, found);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	gmps_req_if req();
	gmps_rsp_if rsp();

	grid_maze_path_search uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	path_scoreboard sb = new();

	rsp_style_t rsp_style = RSP_ALWAYS;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_cnt = 0;
	int stall_ctr = 0;
	int quiet = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Result side: long hold when asked, otherwise the current stall style.
	always @(negedge clk) begin
		stall_ctr++;
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_cnt = LONG_HOLD;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			rsp.ready = 1'b0;
		end else begin
			case (rsp_style)
			RSP_ALWAYS: rsp.ready = 1'b1;
			RSP_COIN: rsp.ready = $urandom_range(0, 1);
			RSP_PATTERN: rsp.ready = (stall_ctr % 7) >= 3;
			default: rsp.ready = $urandom_range(0, 9) != 0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_item(req.kind, req.cell_row, req.cell_col, req.cell_open);
			if (rsp.valid && rsp.ready)
				sb.check_result(rsp.path_found);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("grid_maze_path_search verification failed");
				$finish;
			end
		end
	end

	// Offer one item in bursts, with random gaps when gaps_on is set; returns at the falling edge after accept.
	task automatic send(input logic kind, input logic [POS_W-1:0] row,
	                    input logic [POS_W-1:0] col, input logic open_bit);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on) begin
				req.valid = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
		burst_left--;
		req.valid = 1'b1;
		req.kind = kind;
		req.cell_row = row;
		req.cell_col = col;
		req.cell_open = open_bit;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic search();
		send(KIND_SEARCH, POS_W'($urandom), POS_W'($urandom), 1'($urandom));
	endtask

	// Hold the input until every search has answered and the block has settled.
	task automatic drain();
		req.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = CFG_DATA_W'(value);
		sb.set_reg(idx, CFG_DATA_W'(value));
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply_config(input int rows, input int cols, input int sr, input int sc,
	                            input int er, input int ec);
		drain();
		write_reg(REG_NUM_ROWS, rows);
		write_reg(REG_NUM_COLS, cols);
		write_reg(REG_START_ROW, sr);
		write_reg(REG_START_COL, sc);
		write_reg(REG_END_ROW, er);
		write_reg(REG_END_COL, ec);
	endtask

	function automatic int pick_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 5)
			return 0;
		if (p < 15)
			return $urandom_range(17, 31);
		if (p < 30)
			return $urandom_range(7, 16);
		return $urandom_range(1, 6);
	endfunction

	function automatic int pick_pos(input int lim);
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, lim - 1);
		return $urandom_range(0, 15);
	endfunction

	// Mostly cell loads inside the grid in use, some anywhere, about a third searches.
	task automatic random_item(input int lim_r, input int lim_c);
		logic [POS_W-1:0] r, c;
		if ($urandom_range(0, 99) < 30) begin
			search();
		end else begin
			if ($urandom_range(0, 99) < 80) begin
				r = POS_W'($urandom_range(0, lim_r - 1));
				c = POS_W'($urandom_range(0, lim_c - 1));
			end else begin
				r = POS_W'($urandom);
				c = POS_W'($urandom);
			end
			send(KIND_WRITE, r, c, $urandom_range(0, 99) < 65);
		end
	endtask

	initial begin
		int rows, cols, lim_r, lim_c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_NUM_ROWS;
		cfg_data = '0;
		req.valid = 1'b0;
		req.kind = KIND_WRITE;
		req.cell_row = '0;
		req.cell_col = '0;
		req.cell_open = 1'b0;
		rsp.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// load every cell once so no search ever reads an unwritten cell
		for (int i = 0; i < CELLS; i++)
			send(KIND_WRITE, POS_W'(i / MAX_COLS), POS_W'(i % MAX_COLS),
			     $urandom_range(0, 99) < 65);

		// reset registers: start and goal coincide
		search();
		apply_config(16, 16, 0, 0, 15, 15);
		search();
		// walled start cell still lets the walk leave it
		apply_config(2, 2, 0, 0, 1, 1);
		send(KIND_WRITE, 0, 0, 1'b0);
		send(KIND_WRITE, 0, 1, 1'b1);
		send(KIND_WRITE, 1, 1, 1'b1);
		search();
		send(KIND_WRITE, 0, 1, 1'b0);
		send(KIND_WRITE, 1, 0, 1'b0);
		search();
		// empty grid in either dimension
		apply_config(0, 16, 0, 0, 0, 1);
		search();
		apply_config(16, 0, 0, 0, 1, 0);
		search();
		// oversized grid saturates
		apply_config(31, 31, 0, 0, 15, 15);
		search();
		apply_config(17, 20, 15, 15, 0, 0);
		search();
		// start outside the grid, alone and equal to the goal
		apply_config(4, 4, 5, 0, 0, 0);
		search();
		apply_config(4, 4, 9, 9, 9, 9);
		search();
		// goal outside the grid
		apply_config(4, 4, 0, 0, 6, 2);
		search();

		// back up the result side so the block stalls its input
		apply_config(3, 3, 0, 0, 2, 2);
		gaps_on = 1'b0;
		hold_req++;
		repeat (12) search();
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			gaps_on = $urandom_range(0, 3) != 0;
			rsp_style = rsp_style_t'($urandom_range(0, 3));
			rows = pick_size();
			cols = pick_size();
			lim_r = (rows == 0) ? MAX_ROWS : ((rows > MAX_ROWS) ? MAX_ROWS : rows);
			lim_c = (cols == 0) ? MAX_COLS : ((cols > MAX_COLS) ? MAX_COLS : cols);
			apply_config(rows, cols, pick_pos(lim_r), pick_pos(lim_c),
			             pick_pos(lim_r), pick_pos(lim_c));
			for (int k = 0; k < PHASE_ITEMS; k++)
				random_item(lim_r, lim_c);
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("grid_maze_path_search verification clean");
		else
			$display("grid_maze_path_search verification failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
design/gmps_pkg.sv
design/gmps_if.sv
design/gmps_ram.sv
design/gmps_cfg.sv
design/gmps_walk.sv
design/grid_maze_path_search.sv
design/gmps_chk.sv
test/tb_top.sv
